// ----- hw/rtl/glfr_pkg.sv -----
// ----------------------------------------------------------------------------
// glfr_pkg: shared types and constants for the group-filtered light receiver
// Operation codes, command codes, register indexes, reset values, and the
// state and result records that travel between the receiver modules.
// ----------------------------------------------------------------------------
package glfr_pkg;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_COMMAND = 2'd1,
    OP_COLOUR  = 2'd2,
    OP_UNUSED  = 2'd3
  } op_e;

  typedef enum logic {
    CFG_MY_GROUP      = 1'b0,
    CFG_TIMEOUT_TICKS = 1'b1
  } cfg_index_e;

  localparam logic [7:0]  CodeModelStart   = 8'd200;
  localparam logic [7:0]  CodeModelEnd     = 8'd201;
  localparam logic [7:0]  ColourGroupBits  = 8'h7F;
  localparam logic [7:0]  EffectNone       = 8'hFF;
  localparam logic [7:0]  EffectBlackout   = 8'h00;
  localparam logic [15:0] TimeoutDefault   = 16'd25000;
  localparam logic [15:0] SinceFrameMax    = 16'hFFFF;

  localparam int unsigned InDataWidth  = 48;
  localparam int unsigned OutDataWidth = 80;

  typedef struct packed {
    logic [2:0]  my_group;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic        model_active;
    logic [7:0]  effect_selected;
    logic [7:0]  fixed_red;
    logic [7:0]  fixed_green;
    logic [7:0]  fixed_blue;
    logic [7:0]  fixed_level;
    logic [15:0] since_frame;
  } state_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] group_mask;
    logic       fixed_flag;
    logic [7:0] effect_code;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_brightness;
  } item_t;

  typedef struct packed {
    logic       frame_valid;
    logic [7:0] frame_red;
    logic [7:0] frame_green;
    logic [7:0] frame_blue;
    logic [7:0] frame_brightness;
    logic       timed_out;
  } result_t;

endpackage

// ----- hw/rtl/group_filtered_light_command_receiver_core.sv -----
// ----------------------------------------------------------------------------
// group_filtered_light_command_receiver_core: light command receiver
// Filters command and colour packets by group, tracks external-model mode,
// the selected effect and the fixed colour, and drops model mode on timeout.
// ----------------------------------------------------------------------------
// Every input beat (tick, command or colour packet) produces exactly one
// output beat. A beat lands in an input register, the decision logic runs on
// the held beat, and the result is captured in the output register together
// with the updated state once that register is free or draining. The block
// sustains one beat per clock while the output side keeps taking beats. The
// only throughput limit is the single output register: when the downstream
// side stalls, the input register holds one more beat and then s_axis_tready
// falls. Configuration writes are taken in any cycle (cfg_ready_o is always
// high) but must only be issued while the block holds no beat in flight.
// ----------------------------------------------------------------------------
module group_filtered_light_command_receiver_core (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,   // 0 my_group, 1 timeout_ticks
  input  logic [15:0] cfg_data_i,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: group_mask[7:0], effect_code[15:8], in_red[23:16],
  //        in_green[31:24], in_blue[39:32], in_brightness[47:40]
  input  logic [glfr_pkg::InDataWidth-1:0] s_axis_tdata,
  // tuser: operation[1:0], fixed_flag[2]
  input  logic [2:0]  s_axis_tuser,

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: frame_red[7:0], frame_green[15:8], frame_blue[23:16],
  //        frame_brightness[31:24], external_active[32], current_effect[40:33],
  //        fixed_red[48:41], fixed_green[56:49], fixed_blue[64:57],
  //        fixed_brightness[72:65], timed_out[73], zero padding[79:74]
  output logic [glfr_pkg::OutDataWidth-1:0] m_axis_tdata,
  // tuser: frame_valid[0]
  output logic        m_axis_tuser
);

  glfr_pkg::cfg_t    cfg;
  glfr_pkg::item_t   item_q;
  glfr_pkg::state_t  state_q, state_d;
  glfr_pkg::result_t result_q, result_d;
  logic              in_valid_q;
  logic              out_valid_q;
  logic              advance;

  glfr_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // The held beat moves on when the output register is empty or being drained.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // Payload capture; no reset needed.
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q.operation     <= s_axis_tuser[1:0];
      item_q.fixed_flag    <= s_axis_tuser[2];
      item_q.group_mask    <= s_axis_tdata[7:0];
      item_q.effect_code   <= s_axis_tdata[15:8];
      item_q.in_red        <= s_axis_tdata[23:16];
      item_q.in_green      <= s_axis_tdata[31:24];
      item_q.in_blue       <= s_axis_tdata[39:32];
      item_q.in_brightness <= s_axis_tdata[47:40];
    end
  end

  glfr_step u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // Receiver state only changes when a beat is committed to the output.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.model_active    <= 1'b0;
      state_q.effect_selected <= glfr_pkg::EffectNone;
      state_q.fixed_red       <= 8'd0;
      state_q.fixed_green     <= 8'd0;
      state_q.fixed_blue      <= 8'hFF;
      state_q.fixed_level     <= 8'hFF;
      state_q.since_frame     <= 16'd0;
      out_valid_q             <= 1'b0;
    end else begin
      if (advance) begin
        state_q <= state_d;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  // state_q already holds the post-beat state while result_q is presented.
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = result_q.frame_valid;
  assign m_axis_tdata  = {6'd0,
                          result_q.timed_out,
                          state_q.fixed_level,
                          state_q.fixed_blue,
                          state_q.fixed_green,
                          state_q.fixed_red,
                          state_q.effect_selected,
                          state_q.model_active,
                          result_q.frame_brightness,
                          result_q.frame_blue,
                          result_q.frame_green,
                          result_q.frame_red};

endmodule

// ----- hw/rtl/glfr_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// glfr_cfg_regs: configuration registers
// Holds the group number and the model timeout, written over the cfg channel.
// ----------------------------------------------------------------------------
module glfr_cfg_regs (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_index_i,
  input  logic [15:0]          cfg_data_i,
  output glfr_pkg::cfg_t       cfg_o
);

  glfr_pkg::cfg_t cfg_q, cfg_d;
  glfr_pkg::cfg_index_e index;

  assign cfg_ready_o = 1'b1;
  assign index       = glfr_pkg::cfg_index_e'(cfg_index_i);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (index)
        glfr_pkg::CFG_MY_GROUP:      cfg_d.my_group      = cfg_data_i[2:0];
        glfr_pkg::CFG_TIMEOUT_TICKS: cfg_d.timeout_ticks = cfg_data_i;
        default:                     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.my_group      <= 3'd0;
      cfg_q.timeout_ticks <= glfr_pkg::TimeoutDefault;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/glfr_step.sv -----
// ----------------------------------------------------------------------------
// glfr_step: per-beat decision logic
// From the current state and one registered beat, computes the next state and
// the result record. Purely combinational.
// ----------------------------------------------------------------------------
module glfr_step (
  input  glfr_pkg::cfg_t    cfg_i,
  input  glfr_pkg::state_t  state_i,
  input  glfr_pkg::item_t   item_i,
  output glfr_pkg::state_t  state_o,
  output glfr_pkg::result_t result_o
);

  glfr_pkg::op_e op;
  logic [7:0]    colour_mask;
  logic          cmd_hit;
  logic          colour_hit;
  logic [15:0]   since_inc;
  logic          shown;
  logic          timed_out;

  assign op          = glfr_pkg::op_e'(item_i.operation);
  assign colour_mask = item_i.group_mask & glfr_pkg::ColourGroupBits;
  assign cmd_hit     = item_i.group_mask[cfg_i.my_group];
  assign colour_hit  = colour_mask[cfg_i.my_group];
  assign since_inc   = (state_i.since_frame == glfr_pkg::SinceFrameMax) ?
                       state_i.since_frame : state_i.since_frame + 16'd1;

  always_comb begin
    state_o   = state_i;
    shown     = 1'b0;
    timed_out = 1'b0;
    unique case (op)
      glfr_pkg::OP_TICK: begin
        state_o.since_frame = since_inc;
        if (state_i.model_active && (since_inc > cfg_i.timeout_ticks)) begin
          state_o.model_active    = 1'b0;
          state_o.effect_selected = glfr_pkg::EffectBlackout;
          timed_out               = 1'b1;
        end
      end
      glfr_pkg::OP_COMMAND: begin
        if (cmd_hit) begin
          priority if (item_i.effect_code == glfr_pkg::CodeModelStart) begin
            state_o.model_active = 1'b1;
            state_o.since_frame  = '0;
          end else if (item_i.effect_code == glfr_pkg::CodeModelEnd) begin
            state_o.model_active    = 1'b0;
            state_o.effect_selected = glfr_pkg::EffectBlackout;
          end else begin
            state_o.model_active    = 1'b0;
            state_o.effect_selected = item_i.effect_code;
          end
        end
      end
      glfr_pkg::OP_COLOUR: begin
        if (colour_hit) begin
          if (item_i.fixed_flag) begin
            state_o.fixed_red    = item_i.in_red;
            state_o.fixed_green  = item_i.in_green;
            state_o.fixed_blue   = item_i.in_blue;
            state_o.fixed_level  = item_i.in_brightness;
            state_o.model_active = 1'b0;
          end else begin
            state_o.model_active = 1'b1;
            state_o.since_frame  = '0;
            shown                = 1'b1;
          end
        end
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

  // Frame fields read as zero unless this beat shows a model frame.
  assign result_o.frame_valid      = shown;
  assign result_o.frame_red        = shown ? item_i.in_red : 8'd0;
  assign result_o.frame_green      = shown ? item_i.in_green : 8'd0;
  assign result_o.frame_blue       = shown ? item_i.in_blue : 8'd0;
  assign result_o.frame_brightness = shown ? item_i.in_brightness : 8'd0;
  assign result_o.timed_out        = timed_out;

endmodule
